[hdl/fspa_pkg.sv]
// Shared types and codes of the fixed-slot pool allocator.
// Holds the item structs, command and status codes, and the controller bundle.
// No dependencies.
`timescale 1ns / 1ps

package fspa_pkg;

  localparam int CmdW   = 3;
  localparam int IdxW   = 8;
  localparam int StatW  = 3;
  localparam int CountW = 9;

  typedef enum logic [CmdW-1:0] {
    CMD_ACQUIRE  = 3'd0,
    CMD_RELEASE  = 3'd1,
    CMD_CONTAINS = 3'd2,
    CMD_FIRST    = 3'd3,
    CMD_NEXT     = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_USED  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NONE      = 3'd4
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [IdxW-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic              answer;
    logic [IdxW-1:0]   result_slot;
    logic [CountW-1:0] used_count;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

[hdl/fspa_ctrl.sv]
// Controller of the pool allocator: accepts an item, runs the execute state,
// then strobes the result. Depends on fspa_pkg.
`timescale 1ns / 1ps

module fspa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output fspa_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q == S_EXEC);
  assign done_o        = done_q;
  assign cmd_o.capture = start && (state_q == S_IDLE);
  assign cmd_o.execute = (state_q == S_EXEC);

endmodule

[hdl/fspa_dp.sv]
// Datapath of the pool allocator: free-list link memory, in-use bitmap,
// head, fill mark, used count and the result register. Depends on fspa_pkg.
`timescale 1ns / 1ps

module fspa_dp #(
  parameter int SLOTS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fspa_pkg::ctrl_cmd_t               cmd_i,
  input  fspa_pkg::in_item_t                item_i,
  input  logic                              cfg_we_i,
  input  logic [fspa_pkg::CountW-1:0]       cfg_wdata_i,
  output fspa_pkg::out_item_t               res_o
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW = $clog2(SLOTS + 1);
  localparam int XW = (HW > fspa_pkg::CountW) ? HW + 1 : fspa_pkg::CountW + 1;
  localparam int CountRst = (SLOTS < 256) ? SLOTS : 256;

  logic [HW-1:0] link_mem [SLOTS];
  logic [HW-1:0] link_rd_q;

  logic [fspa_pkg::CountW-1:0] count_q, count_d;
  logic [HW-1:0]               head_q, head_d;
  logic [HW-1:0]               hwm_q, hwm_d;
  logic [fspa_pkg::CountW-1:0] used_q, used_d;
  logic [SLOTS-1:0]            map_q, map_d;
  logic [fspa_pkg::CmdW-1:0]   cmd_q;
  logic [fspa_pkg::IdxW-1:0]   idx_q;
  fspa_pkg::out_item_t         res_q, res_d;

  logic          mem_we;
  logic [XW-1:0] count_x, idx_x, head_x, cfg_x, from_x, pos_x;
  logic [AW-1:0] idx_a;
  logic          in_range, found;

  assign count_x = XW'(count_q);
  assign idx_x   = XW'(idx_q);
  assign head_x  = XW'(head_q);
  assign cfg_x   = XW'(cfg_wdata_i);
  assign idx_a   = idx_x[AW-1:0];
  assign in_range = (idx_x < count_x);

  // Lowest used slot at or above from_x inside the pool
  assign from_x = (cmd_q == fspa_pkg::CMD_FIRST) ? '0 : idx_x + XW'(1);
  always_comb begin
    found = 1'b0;
    pos_x = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (map_q[i] && (XW'(i) >= from_x) && (XW'(i) < count_x)) begin
        found = 1'b1;
        pos_x = XW'(i);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    hwm_d   = hwm_q;
    used_d  = used_q;
    map_d   = map_q;
    mem_we  = 1'b0;
    res_d   = res_q;
    if (cfg_we_i) begin
      if (cfg_x == '0) begin
        count_d = fspa_pkg::CountW'(1);
      end else if (cfg_x > XW'(SLOTS)) begin
        count_d = fspa_pkg::CountW'(SLOTS);
      end else begin
        count_d = cfg_wdata_i;
      end
      head_d = '0;
      hwm_d  = '0;
      used_d = '0;
      map_d  = '0;
    end else if (cmd_i.execute) begin
      res_d = '0;
      case (cmd_q)
        fspa_pkg::CMD_ACQUIRE: begin
          if (head_x < count_x) begin
            map_d[head_q[AW-1:0]] = 1'b1;
            used_d = used_q + fspa_pkg::CountW'(1);
            res_d.answer      = 1'b1;
            res_d.result_slot = head_x[fspa_pkg::IdxW-1:0];
            // Slots at or above the fill mark still hold the initial chain
            if (head_q >= hwm_q) begin
              hwm_d  = hwm_q + HW'(1);
              head_d = (head_x + XW'(1) < count_x) ? head_q + HW'(1) : HW'(SLOTS);
            end else begin
              head_d = link_rd_q;
            end
          end else begin
            res_d.status = fspa_pkg::ST_EMPTY;
          end
        end
        fspa_pkg::CMD_RELEASE: begin
          if (!in_range) begin
            res_d.status = fspa_pkg::ST_RANGE;
          end else if (!map_q[idx_a]) begin
            res_d.status = fspa_pkg::ST_NOT_USED;
          end else begin
            map_d[idx_a] = 1'b0;
            mem_we = 1'b1;
            head_d = HW'(idx_x);
            used_d = used_q - fspa_pkg::CountW'(1);
          end
        end
        fspa_pkg::CMD_CONTAINS: begin
          if (!in_range) begin
            res_d.status = fspa_pkg::ST_RANGE;
          end else begin
            res_d.answer = map_q[idx_a];
          end
        end
        fspa_pkg::CMD_FIRST, fspa_pkg::CMD_NEXT: begin
          if ((cmd_q == fspa_pkg::CMD_NEXT) && !in_range) begin
            res_d.status = fspa_pkg::ST_RANGE;
          end else if (found) begin
            res_d.answer      = 1'b1;
            res_d.result_slot = pos_x[fspa_pkg::IdxW-1:0];
          end else begin
            res_d.status = fspa_pkg::ST_NONE;
          end
        end
        default: begin
        end
      endcase
      res_d.used_count = used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= fspa_pkg::CountW'(CountRst);
      head_q  <= '0;
      hwm_q   <= '0;
      used_q  <= '0;
      map_q   <= '0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      hwm_q   <= hwm_d;
      used_q  <= used_d;
      map_q   <= map_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.capture) begin
      cmd_q <= item_i.command;
      idx_q <= item_i.slot_index;
    end
  end

  // Link memory: write on release, read the head's link when an item enters
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[idx_a] <= head_q;
    end
    if (cmd_i.capture) begin
      link_rd_q <= link_mem[head_q[AW-1:0]];
    end
  end

  assign res_o = res_q;

endmodule

[hdl/fixed_slot_pool_allocator_core.sv]
// Top level of the fixed-slot pool allocator: controller plus datapath.
// Depends on fspa_pkg, fspa_ctrl and fspa_dp.
`timescale 1ns / 1ps

// Usage:
// Drive in_i with a command and slot index and raise start. The item is taken
// at a clock edge where start is high and busy is low. busy is high for the
// one execute cycle that follows, and no new item is taken while busy is high.
// The result appears on res_o with done_o high for exactly one cycle, in the
// cycle after the execute cycle; res_o then holds it until the next item
// executes. The receiver cannot stall it.
// The cost of an item is set by the registered read of the free-list link
// memory at the accepting edge, used in the execute cycle; the bitmap search
// for first and next is a priority encoder in that cycle.
// Reset clears the bitmap, head, used count and fill mark and sets the slot
// count to 256 (or SLOTS if smaller); no clearing pass is needed, since
// links at or above the fill mark are taken from the initial in-order chain.
// A write on cfg_we_i sets slot_count (0 reads as 1, values above SLOTS as
// SLOTS) and rebuilds the pool in the same cycle; write only while idle.
module fixed_slot_pool_allocator_core #(
  parameter int SLOTS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  fspa_pkg::in_item_t          in_i,
  output logic                        done_o,
  output fspa_pkg::out_item_t         res_o,
  input  logic                        cfg_we_i,
  input  logic [fspa_pkg::CountW-1:0] cfg_wdata_i
);

  fspa_pkg::ctrl_cmd_t cmd;

  fspa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  fspa_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res_o)
  );

endmodule

[sim/tb.sv]
// Self-checking testbench for fixed_slot_pool_allocator_core.
// Predicts each result from a local copy of the pool state and checks done_o items.
// Depends on fspa_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS       = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_WAIT  = 4;

  // Command codes the block does not decode
  localparam logic [fspa_pkg::CmdW-1:0] CMD_RESERVED_FIRST = 3'd5;
  localparam logic [fspa_pkg::CmdW-1:0] CMD_RESERVED_LAST  = 3'd7;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        start       = 1'b0;
  logic                        busy;
  fspa_pkg::in_item_t          in_i        = '0;
  logic                        done_o;
  fspa_pkg::out_item_t         res_o;
  logic                        cfg_we_i    = 1'b0;
  logic [fspa_pkg::CountW-1:0] cfg_wdata_i = '0;

  // Local copy of the pool
  logic [fspa_pkg::CountW-1:0] live_slots;
  logic [fspa_pkg::CountW-1:0] free_link [SLOTS];
  logic [fspa_pkg::CountW-1:0] free_head;
  logic                        in_use [SLOTS];
  logic [fspa_pkg::CountW-1:0] used_total;

  fspa_pkg::out_item_t pending_results [$];
  fspa_pkg::out_item_t oldest;
  int                  error_count = 0;
  int                  cycle_count = 0;
  bit                  gapless     = 1'b0;

  fixed_slot_pool_allocator_core #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void pool_rebuild(input logic [fspa_pkg::CountW-1:0] value);
    int i;
    live_slots = value;
    if (value < fspa_pkg::CountW'(1)) live_slots = fspa_pkg::CountW'(1);
    if (value > fspa_pkg::CountW'(SLOTS)) live_slots = fspa_pkg::CountW'(SLOTS);
    for (i = 0; i < SLOTS; i++) begin
      free_link[i] = (i + 1 < int'(live_slots)) ? fspa_pkg::CountW'(i + 1)
                                                : fspa_pkg::CountW'(SLOTS);
      in_use[i]    = 1'b0;
    end
    free_head  = '0;
    used_total = '0;
  endfunction

  function automatic fspa_pkg::out_item_t pool_apply(input fspa_pkg::in_item_t item);
    fspa_pkg::out_item_t         r;
    logic [fspa_pkg::IdxW-1:0]   idx;
    logic [fspa_pkg::IdxW-1:0]   head;
    int                          from;
    int                          found;
    int                          i;
    r    = '0;
    idx  = item.slot_index;
    head = free_head[fspa_pkg::IdxW-1:0];
    case (item.command)
      fspa_pkg::CMD_ACQUIRE: begin
        if (free_head >= live_slots) begin
          r.status = fspa_pkg::ST_EMPTY;
        end else begin
          r.answer      = 1'b1;
          r.result_slot = head;
          in_use[head]  = 1'b1;
          free_head     = free_link[head];
          used_total    = used_total + fspa_pkg::CountW'(1);
        end
      end
      fspa_pkg::CMD_RELEASE: begin
        if (fspa_pkg::CountW'(idx) >= live_slots) begin
          r.status = fspa_pkg::ST_RANGE;
        end else if (!in_use[idx]) begin
          r.status = fspa_pkg::ST_NOT_USED;
        end else begin
          in_use[idx]    = 1'b0;
          free_link[idx] = free_head;
          free_head      = fspa_pkg::CountW'(idx);
          used_total     = used_total - fspa_pkg::CountW'(1);
        end
      end
      fspa_pkg::CMD_CONTAINS: begin
        if (fspa_pkg::CountW'(idx) >= live_slots) r.status = fspa_pkg::ST_RANGE;
        else r.answer = in_use[idx];
      end
      fspa_pkg::CMD_FIRST, fspa_pkg::CMD_NEXT: begin
        if (item.command == fspa_pkg::CMD_NEXT &&
            fspa_pkg::CountW'(idx) >= live_slots) begin
          r.status = fspa_pkg::ST_RANGE;
        end else begin
          from  = (item.command == fspa_pkg::CMD_FIRST) ? 0 : int'(idx) + 1;
          found = SLOTS;
          for (i = from; i < int'(live_slots); i++) begin
            if (in_use[i] && found == SLOTS) found = i;
          end
          if (found == SLOTS) begin
            r.status = fspa_pkg::ST_NONE;
          end else begin
            r.answer      = 1'b1;
            r.result_slot = found[fspa_pkg::IdxW-1:0];
          end
        end
      end
      default: ;
    endcase
    r.used_count = used_total;
    return r;
  endfunction

  // Random slot that is in use, or any slot in range when none is
  function automatic logic [fspa_pkg::IdxW-1:0] pick_used_slot();
    int base;
    int k;
    int s;
    base = int'($urandom_range(0, int'(live_slots) - 1));
    for (k = 0; k < int'(live_slots); k++) begin
      s = (base + k) % int'(live_slots);
      if (in_use[s]) return s[fspa_pkg::IdxW-1:0];
    end
    return base[fspa_pkg::IdxW-1:0];
  endfunction

  task automatic note_error(input string what, input fspa_pkg::out_item_t want,
                            input fspa_pkg::out_item_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s: expected status %0d answer %0d slot %0d used %0d",
               what, want.status, want.answer, want.result_slot, want.used_count);
      $display("%s: got      status %0d answer %0d slot %0d used %0d",
               what, got.status, got.answer, got.result_slot, got.used_count);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        note_error("result with no pending item", '0, res_o);
      end else begin
        oldest = pending_results.pop_front();
        if (res_o.status !== oldest.status || res_o.answer !== oldest.answer ||
            res_o.result_slot !== oldest.result_slot ||
            res_o.used_count !== oldest.used_count) begin
          note_error("result mismatch", oldest, res_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic issue_command(input logic [fspa_pkg::CmdW-1:0] cmd,
                               input logic [fspa_pkg::IdxW-1:0] idx);
    fspa_pkg::in_item_t item;
    int                 gap;
    item.command    = cmd;
    item.slot_index = idx;
    in_i  <= item;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(pool_apply(item));
    gap = gapless ? 0 : int'($urandom_range(0, 7));
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [fspa_pkg::CountW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    pool_rebuild(value);
    cfg_we_i    <= 1'b0;
  endtask

  // Pool straight out of reset: 256 slots, none used
  task automatic test_fresh_pool();
    int k;
    issue_command(fspa_pkg::CMD_FIRST, 8'd0);
    issue_command(fspa_pkg::CMD_NEXT, 8'hFF);
    issue_command(fspa_pkg::CMD_CONTAINS, 8'hFF);
    issue_command(fspa_pkg::CMD_RELEASE, 8'd5);
    repeat (3) issue_command(fspa_pkg::CMD_ACQUIRE, 8'hFF);
    issue_command(fspa_pkg::CMD_NEXT, 8'd0);
    issue_command(fspa_pkg::CMD_NEXT, 8'd2);
    issue_command(fspa_pkg::CMD_RELEASE, 8'd1);
    issue_command(fspa_pkg::CMD_ACQUIRE, 8'd0);
    for (k = int'(CMD_RESERVED_FIRST); k <= int'(CMD_RESERVED_LAST); k++) begin
      issue_command(fspa_pkg::CmdW'(k), 8'hFF);
    end
  endtask

  // A write of zero leaves a single slot: exercise empty and range cases
  task automatic test_tiny_pool();
    write_slot_count(9'd0);
    issue_command(fspa_pkg::CMD_ACQUIRE, 8'd0);
    issue_command(fspa_pkg::CMD_ACQUIRE, 8'd0);
    issue_command(fspa_pkg::CMD_RELEASE, 8'd1);
    issue_command(fspa_pkg::CMD_CONTAINS, 8'd1);
    issue_command(fspa_pkg::CMD_CONTAINS, 8'd0);
    issue_command(fspa_pkg::CMD_NEXT, 8'd1);
    issue_command(fspa_pkg::CMD_NEXT, 8'd0);
    issue_command(fspa_pkg::CMD_FIRST, 8'd0);
    issue_command(fspa_pkg::CMD_RELEASE, 8'd0);
    issue_command(fspa_pkg::CMD_RELEASE, 8'd0);
  endtask

  task automatic test_random_traffic();
    logic [fspa_pkg::CountW-1:0] sizes [9];
    int                          acquire_pct [9];
    int                          item_total [9];
    int                          p;
    int                          n;
    int                          roll;
    logic [fspa_pkg::CmdW-1:0]   cmd;
    logic [fspa_pkg::IdxW-1:0]   idx;
    sizes       = '{9'd256, 9'd16, 9'd1, 9'd2, 9'd3, 9'd0, 9'd511, 9'd255, 9'd0};
    acquire_pct = '{70, 40, 40, 40, 50, 40, 40, 60, 45};
    item_total  = '{500, 200, 60, 60, 80, 40, 200, 200, 110};
    sizes[8]    = fspa_pkg::CountW'($urandom_range(0, 511));
    for (p = 0; p < 9; p++) begin
      write_slot_count(sizes[p]);
      for (n = 0; n < item_total[p]; n++) begin
        if (n % 32 == 0) gapless = ($urandom_range(0, 3) == 0);
        idx = fspa_pkg::IdxW'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < acquire_pct[p]) begin
          cmd = fspa_pkg::CMD_ACQUIRE;
        end else begin
          roll = int'($urandom_range(0, 99));
          if (roll < 45) begin
            cmd = fspa_pkg::CMD_RELEASE;
            if ($urandom_range(0, 9) < 7) idx = pick_used_slot();
          end else if (roll < 95) begin
            if (roll < 70) cmd = fspa_pkg::CMD_CONTAINS;
            else if (roll < 80) cmd = fspa_pkg::CMD_FIRST;
            else cmd = fspa_pkg::CMD_NEXT;
            // Keep most indexes inside the pool
            if ($urandom_range(0, 9) < 8) begin
              idx = fspa_pkg::IdxW'($urandom_range(0, int'(live_slots) - 1));
            end
          end else begin
            cmd = fspa_pkg::CmdW'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
          end
        end
        issue_command(cmd, idx);
      end
    end
    gapless = 1'b0;
  endtask

  initial begin
    pool_rebuild(9'd256);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_fresh_pool();
    test_tiny_pool();
    test_random_traffic();
    drain();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/fspa_pkg.sv
hdl/fspa_ctrl.sv
hdl/fspa_dp.sv
hdl/fixed_slot_pool_allocator_core.sv
sim/tb.sv
